@@ rtl/rrlb_pkg.sv @@
// shared types and constants for the record ring log buffer
package rrlb_pkg;

    localparam int CNT_W  = 13;
    localparam int BYTE_W = 8;

    localparam logic [CNT_W-1:0] USED_MAX      = 13'h1FFF;
    localparam logic [CNT_W-1:0] THRESH_RESET  = 13'd4096;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic read_valid;
        logic buffer_empty;
        logic threshold_reached;
    } t_status;

endpackage

@@ rtl/record_ring_log_buffer_core.sv @@
// top level of the record ring log buffer
//
// byte ring for log records that never splits a record across the end
// input channel: i_in_valid / o_in_stall, one word per write or read byte
// output channel: o_out_valid / i_out_stall, one result word per input word
// config channel: i_cfg_valid / o_cfg_ready carries the fill threshold,
//   always ready, write only while the block is idle
// result: registered, shown in the cycle after the input word is taken
// throughput: one word per cycle while the output is not held; the pointer logic updates in the accept
//   cycle and the memory is read or written at most once per word, read data is
//   registered in the memory and shown with the result
// stall: while the output is held, o_in_stall is high and the input waits;
//   read data stays in the memory's output register until the next read
// reset: pointers, fill count and output valid clear, the threshold
//   returns to 4096, the byte store is not cleared
module record_ring_log_buffer_core
    import rrlb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_operation,
    input  logic              i_record_start,
    input  logic [CNT_W-1:0]  i_record_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_read_byte,
    output logic              o_read_valid,
    output logic              o_buffer_empty,
    output logic              o_threshold_reached,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int PW = $clog2(BUFFER_DEPTH + 1);

    logic              accept;
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    t_status           status;

    logic              r_out_valid;
    t_status           r_status;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;

    rrlb_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW),
        .PW           (PW)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_operation     (i_operation),
        .i_record_start  (i_record_start),
        .i_record_length (i_record_length),
        .i_data_byte     (i_data_byte),
        .i_cfg_we        (i_cfg_valid && o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .o_mem_ctl       (mem_ctl),
        .o_mem_addr      (mem_addr),
        .o_mem_wdata     (mem_wdata),
        .o_status        (status)
    );

    rrlb_mem #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .AW           (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= status;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_read_byte         = r_status.read_valid ? mem_rdata : '0;
    assign o_read_valid        = r_status.read_valid;
    assign o_buffer_empty      = r_status.buffer_empty;
    assign o_threshold_reached = r_status.threshold_reached;

endmodule

@@ rtl/rrlb_mem.sv @@
// byte store: single-port synchronous memory with registered read data
module rrlb_mem
    import rrlb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 4096,
    parameter int AW           = 12
) (
    input  logic              i_clk,
    input  t_mem_ctl          i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [BYTE_W-1:0] i_wdata,
    output logic [BYTE_W-1:0] o_rdata
);

    logic [BYTE_W-1:0] r_store [BUFFER_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_store[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rdata <= r_store[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/rrlb_ctrl.sv @@
// pointer, wrap marker, fill count and threshold logic of the ring
module rrlb_ctrl
    import rrlb_pkg::*;
#(
    parameter int BUFFER_DEPTH = 4096,
    parameter int AW           = 12,
    parameter int PW           = 13
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_operation,
    input  logic              i_record_start,
    input  logic [CNT_W-1:0]  i_record_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output t_mem_ctl          o_mem_ctl,
    output logic [AW-1:0]     o_mem_addr,
    output logic [BYTE_W-1:0] o_mem_wdata,
    output t_status           o_status
);

    localparam int LW = ((CNT_W > PW) ? CNT_W : PW) + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

    logic [PW-1:0]    r_wp, n_wp;
    logic [PW-1:0]    r_rp, n_rp;
    logic [PW-1:0]    r_marker, n_marker;
    logic             r_wrapped, n_wrapped;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic [CNT_W-1:0] r_thresh, n_thresh;

    logic [LW-1:0]    len_v;
    logic             store;

    always_comb begin
        n_wp        = r_wp;
        n_rp        = r_rp;
        n_marker    = r_marker;
        n_wrapped   = r_wrapped;
        n_used      = r_used;
        n_rem       = r_rem;
        n_thresh    = i_cfg_we ? i_cfg_data : r_thresh;
        len_v       = '0;
        store       = 1'b0;
        o_mem_ctl   = '0;
        o_mem_addr  = '0;
        o_mem_wdata = i_data_byte;
        o_status    = '0;
        if (i_accept) begin
            if (i_operation == OP_WRITE) begin
                if (i_record_start) begin
                    len_v = LW'(i_record_length);
                    if (len_v == '0) begin
                        len_v = LW'(1);
                    end
                    if (len_v > DEPTH_L) begin
                        len_v = DEPTH_L;
                    end
                    if (LW'(r_wp) + len_v > DEPTH_L) begin
                        n_marker  = r_wp;
                        n_wp      = '0;
                        n_wrapped = 1'b1;
                    end
                    n_rem = CNT_W'(len_v);
                    store = 1'b1;
                end else if (r_rem != '0) begin
                    store = 1'b1;
                end
                if (store && (n_wp < DEPTH_P)) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_mem_addr      = n_wp[AW-1:0];
                    n_wp            = n_wp + PW'(1);
                    if (n_used < USED_MAX) begin
                        n_used = n_used + CNT_W'(1);
                    end
                    n_rem = n_rem - CNT_W'(1);
                    o_status.threshold_reached = (n_rem == '0) && (n_used > r_thresh);
                end else if (store) begin
                    n_rem = '0;
                end
            end else begin
                if (r_rp != r_wp) begin
                    if ((r_wrapped && (r_rp >= r_marker)) || (r_rp >= DEPTH_P)) begin
                        n_rp      = '0;
                        n_wrapped = 1'b0;
                    end
                    if ((n_rp != r_wp) && (n_rp < DEPTH_P)) begin
                        o_mem_ctl.rd_en     = 1'b1;
                        o_mem_addr          = n_rp[AW-1:0];
                        o_status.read_valid = 1'b1;
                        n_rp                = n_rp + PW'(1);
                        if (n_used != '0) begin
                            n_used = n_used - CNT_W'(1);
                        end
                    end
                end
            end
        end
        o_status.buffer_empty = (n_rp == n_wp);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_marker  <= '0;
            r_wrapped <= 1'b0;
            r_used    <= '0;
            r_rem     <= '0;
            r_thresh  <= THRESH_RESET;
        end else begin
            r_wp      <= n_wp;
            r_rp      <= n_rp;
            r_marker  <= n_marker;
            r_wrapped <= n_wrapped;
            r_used    <= n_used;
            r_rem     <= n_rem;
            r_thresh  <= n_thresh;
        end
    end

endmodule

@@ rtl/rrlb_checker.sv @@
// port-level checker for the record ring log buffer and its bind
module rrlb_port_checks
    import rrlb_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              i_operation,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [BYTE_W-1:0] o_read_byte,
    input logic              o_read_valid,
    input logic              o_threshold_reached
);

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted word produced no result");

    a_write_no_read_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_operation == OP_WRITE) |=> !o_read_valid)
        else $error("write word returned read data");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_read_valid && o_threshold_reached))
        else $error("read result carries threshold flag");

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_byte))
        else $error("stalled result changed");

endmodule

bind record_ring_log_buffer_core rrlb_port_checks u_rrlb_port_checks (.*);

@@ tb/sv/rrlb_checker.sv @@
// watches the record ring log buffer channels, predicts each result word and compares
`timescale 1ns / 1ps

module rrlb_checker
    import rrlb_pkg::*;
#(
    parameter int RING_DEPTH = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic              i_operation,
    input  logic              i_record_start,
    input  logic [CNT_W-1:0]  i_record_length,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  logic [BYTE_W-1:0] i_read_byte,
    input  logic              i_read_valid,
    input  logic              i_buffer_empty,
    input  logic              i_threshold_reached,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int                o_mismatches,
    output int                o_pending
);

    typedef struct packed {
        logic [BYTE_W-1:0] popped;
        logic              popped_valid;
        logic              ring_empty;
        logic              over_threshold;
    } t_ring_status;

    logic [BYTE_W-1:0] ring_mem [RING_DEPTH];
    logic [CNT_W-1:0]  wr_ptr;
    logic [CNT_W-1:0]  rd_ptr;
    logic [CNT_W-1:0]  wrap_at;
    logic              wrapped;
    logic [CNT_W-1:0]  used_bytes;
    logic [CNT_W-1:0]  record_left;
    logic [CNT_W-1:0]  fill_limit;

    t_ring_status expected_status [$];

    task automatic advance_ring(input logic op, input logic start,
                                input logic [CNT_W-1:0] len_in,
                                input logic [BYTE_W-1:0] data, output t_ring_status res);
        int  len;
        bit  store;
        res   = '0;
        store = 1'b0;
        len   = len_in;
        if (op == OP_WRITE) begin
            if (start) begin
                if (len == 0) len = 1;
                if (len > RING_DEPTH) len = RING_DEPTH;
                if (int'(wr_ptr) + len > RING_DEPTH) begin
                    wrap_at = wr_ptr;
                    wr_ptr  = '0;
                    wrapped = 1'b1;
                end
                record_left = CNT_W'(len);
                store       = 1'b1;
            end else if (record_left != 0) begin
                store = 1'b1;
            end
            if (store && wr_ptr < RING_DEPTH) begin
                ring_mem[wr_ptr] = data;
                wr_ptr           = wr_ptr + 1'b1;
                if (used_bytes < USED_MAX) used_bytes = used_bytes + 1'b1;
                record_left = record_left - 1'b1;
                if (record_left == 0 && used_bytes > fill_limit) res.over_threshold = 1'b1;
            end else if (store) begin
                record_left = '0;
            end
        end else if (rd_ptr != wr_ptr) begin
            if ((wrapped && rd_ptr >= wrap_at) || rd_ptr >= RING_DEPTH) begin
                rd_ptr  = '0;
                wrapped = 1'b0;
            end
            if (rd_ptr != wr_ptr && rd_ptr < RING_DEPTH) begin
                res.popped       = ring_mem[rd_ptr];
                res.popped_valid = 1'b1;
                rd_ptr           = rd_ptr + 1'b1;
                if (used_bytes > 0) used_bytes = used_bytes - 1'b1;
            end
        end
        res.ring_empty = (rd_ptr == wr_ptr);
    endtask

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_ring_status got;
        t_ring_status want;
        if (!i_rst_n) begin
            wr_ptr      = '0;
            rd_ptr      = '0;
            wrap_at     = '0;
            wrapped     = 1'b0;
            used_bytes  = '0;
            record_left = '0;
            fill_limit  = THRESH_RESET;
            expected_status.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) fill_limit = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got.popped         = i_read_byte;
                got.popped_valid   = i_read_valid;
                got.ring_empty     = i_buffer_empty;
                got.over_threshold = i_threshold_reached;
                if (expected_status.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: nothing expected, got byte %0h valid %0b empty %0b thr %0b",
                             $time, got.popped, got.popped_valid, got.ring_empty,
                             got.over_threshold);
                end else begin
                    want = expected_status.pop_front();
                    if (got !== want) begin
                        o_mismatches++;
                        // byte / valid / empty / threshold
                        $display("%0t: expected %0h/%0b/%0b/%0b got %0h/%0b/%0b/%0b",
                                 $time, want.popped, want.popped_valid, want.ring_empty,
                                 want.over_threshold, got.popped, got.popped_valid,
                                 got.ring_empty, got.over_threshold);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                advance_ring(i_operation, i_record_start, i_record_length, i_data_byte, want);
                expected_status.push_back(want);
            end
        end
        o_pending = expected_status.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
// top of the record ring log buffer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
    import rrlb_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int CYCLE_LIMIT = 4000000;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_operation;
    logic              i_record_start;
    logic [CNT_W-1:0]  i_record_length;
    logic [BYTE_W-1:0] i_data_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BYTE_W-1:0] o_read_byte;
    logic              o_read_valid;
    logic              o_buffer_empty;
    logic              o_threshold_reached;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data;

    int mismatches;
    int pending;
    int tx_count    = 0;
    int rx_count    = 0;
    int cycle_count = 0;
    bit quiet       = 1'b0;
    bit long_hold   = 1'b0;

    record_ring_log_buffer_core #(
        .BUFFER_DEPTH(RING_DEPTH)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_record_start     (i_record_start),
        .i_record_length    (i_record_length),
        .i_data_byte        (i_data_byte),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_read_byte        (o_read_byte),
        .o_read_valid       (o_read_valid),
        .o_buffer_empty     (o_buffer_empty),
        .o_threshold_reached(o_threshold_reached),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data)
    );

    rrlb_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) checker_inst (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_operation        (i_operation),
        .i_record_start     (i_record_start),
        .i_record_length    (i_record_length),
        .i_data_byte        (i_data_byte),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_read_byte        (o_read_byte),
        .i_read_valid       (o_read_valid),
        .i_buffer_empty     (o_buffer_empty),
        .i_threshold_reached(o_threshold_reached),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_mismatches       (mismatches),
        .o_pending          (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (o_out_valid && !i_out_stall) rx_count <= rx_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side stall pattern
    initial begin
        int run_len;
        int hold_len;
        i_out_stall = 1'b0;
        forever begin
            run_len = $urandom_range(1, 16);
            repeat (run_len) @(negedge i_clk) i_out_stall = 1'b0;
            if (long_hold) begin
                long_hold = 1'b0;
                hold_len  = 120;
            end else if (quiet) begin
                hold_len = 0;
            end else begin
                hold_len = pick_pause();
            end
            repeat (hold_len) @(negedge i_clk) i_out_stall = 1'b1;
        end
    end

    task automatic send_word(input logic op, input logic start, input int len, input int data);
        int gap;
        gap = quiet ? 0 : pick_pause();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_operation     = op;
        i_record_start  = start;
        i_record_length = CNT_W'(len);
        i_data_byte     = BYTE_W'(data);
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tx_count++;
    endtask

    task automatic send_read();
        send_word(OP_READ, 1'($urandom_range(0, 1)), $urandom_range(0, 8191),
                  $urandom_range(0, 255));
    endtask

    task automatic send_record(input int len_field, input int n_bytes);
        send_word(OP_WRITE, 1'b1, len_field, $urandom_range(0, 255));
        for (int i = 1; i < n_bytes; i++)
            send_word(OP_WRITE, 1'b0, $urandom_range(0, 8191), $urandom_range(0, 255));
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (rx_count == tx_count);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_threshold(input int value);
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = CNT_W'(value);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_traffic(input int n_words, input int read_pct);
        int target;
        int kind;
        int len;
        target = tx_count + n_words;
        while (tx_count < target) begin
            if ($urandom_range(0, 99) < read_pct) begin
                send_read();
            end else begin
                kind = $urandom_range(0, 99);
                if (kind < 70) begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                      : $urandom_range(1, 24);
                    send_record((len == 1 && $urandom_range(0, 1)) ? 0 : len, len);
                end else if (kind < 85) begin
                    // random length field that may force a wrap, record usually cut short by the next start
                    send_record($urandom_range(0, 8191), $urandom_range(1, 6));
                end else begin
                    repeat ($urandom_range(1, 3))
                        send_word(OP_WRITE, 1'b0, $urandom_range(0, 8191),
                                  $urandom_range(0, 255));
                end
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_operation     = OP_WRITE;
        i_record_start  = 1'b0;
        i_record_length = '0;
        i_data_byte     = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_data      = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_threshold(THRESH_RESET);

        // empty ring, stray word, start flag on reads
        send_word(OP_READ, 1'b0, 0, 8'hFF);
        send_word(OP_READ, 1'b1, 5, 8'h00);
        send_word(OP_WRITE, 1'b0, 0, 8'hFF);
        // zero length record, then a short one
        send_word(OP_WRITE, 1'b1, 0, 8'h00);
        send_word(OP_WRITE, 1'b1, 2, 8'hA5);
        send_word(OP_WRITE, 1'b0, 0, 8'h5A);
        send_read();
        send_read();
        // open record abandoned by a new start
        send_record(6, 2);
        send_record(4, 4);
        repeat (4) send_read();

        write_threshold(0);
        run_traffic(250, 85);

        write_threshold($urandom_range(3700, 4096));
        long_hold = 1'b1;
        run_traffic(250, 92);

        write_threshold(4096);
        quiet = 1'b1;
        run_traffic(120, 88);
        quiet = 1'b0;
        run_traffic(130, 88);

        write_threshold($urandom_range(0, 4096));
        run_traffic(60, 60);

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rrlb_pkg.sv
rtl/rrlb_mem.sv
rtl/rrlb_ctrl.sv
rtl/record_ring_log_buffer_core.sv
rtl/rrlb_checker.sv
tb/sv/rrlb_checker.sv
tb/sv/tb_top.sv
